// ===== rtl/scg_pkg.sv =====
`default_nettype none

package scg_pkg;

	// pixel and field widths
	localparam int PIXEL_W  = 8;
	localparam int GRAD_W   = 13;
	localparam int ROW_W    = 12;
	localparam int COL_W    = 10;
	localparam int IMG_W_W  = 11;
	localparam int IMG_H_W  = 12;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 1;

	// default line length the line store is sized for
	localparam int MAX_WIDTH_DEF = 1024;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// register reset values
	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

	// one result beat, before the run flag is attached
	typedef struct packed {
		logic [GRAD_W-1:0] grad_x;
		logic [GRAD_W-1:0] grad_y;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              done;
	} res_t;

	// raster position flags of one pixel, worked out when it is taken in
	typedef struct packed {
		logic             upper_valid; // row above exists, so a delayed-row result is due
		logic             has_above;   // two rows above exist
		logic             last_row;
		logic             height_one;
		logic             col_zero;
		logic             col_one;
		logic             col_end;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/scg_line_ram.sv =====
`default_nettype none

module scg_line_ram #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 16
) (
	input  wire                       clk,
	input  wire                       rd_en,
	input  wire [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [DATA_W-1:0]         rd_data,
	input  wire                       wr_en,
	input  wire [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire [DATA_W-1:0]          wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scg_grad_calc.sv =====
`default_nettype none

module scg_grad_calc (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        adv,
	input  scg_pkg::ctl_t              ctl,
	input  wire [scg_pkg::PIXEL_W-1:0] pixel,
	input  wire [scg_pkg::PIXEL_W-1:0] older,
	input  wire [scg_pkg::PIXEL_W-1:0] newer,
	output scg_pkg::res_t [3:0]        res_list,
	output logic [2:0]                 res_cnt
);

	import scg_pkg::*;

	function automatic logic [GRAD_W-1:0] times3(input logic [GRAD_W-1:0] x);
		return x + {x[GRAD_W-2:0], 1'b0};
	endfunction

	function automatic logic [GRAD_W-1:0] times6(input logic [GRAD_W-1:0] x);
		return {x[GRAD_W-3:0], 2'b00} + {x[GRAD_W-2:0], 1'b0};
	endfunction

	function automatic logic [GRAD_W-1:0] times10(input logic [GRAD_W-1:0] x);
		return {x[GRAD_W-4:0], 3'b000} + {x[GRAD_W-2:0], 1'b0};
	endfunction

	function automatic logic [GRAD_W-1:0] sext9(input logic [8:0] x);
		return {{(GRAD_W-9){x[8]}}, x};
	endfunction

	// column windows: _old is two columns back, _new one column back
	logic [GRAD_W-1:0] sm0_old_q, sm0_new_q;
	logic [8:0]        df0_old_q, df0_new_q;
	logic [GRAD_W-1:0] sm1_old_q, sm1_new_q;

	logic [PIXEL_W-1:0] above, below_last;
	logic [GRAD_W-1:0]  sm0, sm1;
	logic [8:0]         df0;
	logic [GRAD_W-1:0]  sl0, sl1;
	logic [8:0]         dl0, d1e;
	res_t [3:0]         cand;
	logic [3:0]         cand_v;

	assign above      = ctl.has_above ? older : pixel;
	assign below_last = ctl.height_one ? pixel : newer;

	assign sm0 = times3(GRAD_W'(above) + GRAD_W'(pixel)) + times10(GRAD_W'(newer));
	assign df0 = 9'(pixel) - 9'(above);
	assign sm1 = times6(GRAD_W'(below_last)) + times10(GRAD_W'(pixel));

	// reflect at the left edge: column -1 reads column 1
	assign sl0 = ctl.col_one ? sm0 : sm0_old_q;
	assign dl0 = ctl.col_one ? df0 : df0_old_q;
	assign sl1 = ctl.col_one ? sm1 : sm1_old_q;
	// reflect at the right edge; a one-column row reads itself
	assign d1e = ctl.col_zero ? df0 : df0_new_q;

	always_comb begin
		cand[0].grad_x = sm0 - sl0;
		cand[0].grad_y = times3(sext9(dl0) + sext9(df0)) + times10(sext9(df0_new_q));
		cand[0].row    = ctl.row - ROW_W'(1);
		cand[0].col    = ctl.col - COL_W'(1);
		cand[0].done   = 1'b0;

		cand[1].grad_x = '0;
		cand[1].grad_y = times6(sext9(d1e)) + times10(sext9(df0));
		cand[1].row    = ctl.row - ROW_W'(1);
		cand[1].col    = ctl.col;
		cand[1].done   = 1'b0;

		// last row: diff is zero everywhere
		cand[2].grad_x = sm1 - sl1;
		cand[2].grad_y = '0;
		cand[2].row    = ctl.row;
		cand[2].col    = ctl.col - COL_W'(1);
		cand[2].done   = 1'b0;

		cand[3].grad_x = '0;
		cand[3].grad_y = '0;
		cand[3].row    = ctl.row;
		cand[3].col    = ctl.col;
		cand[3].done   = 1'b1;

		cand_v[0] = ctl.upper_valid && !ctl.col_zero;
		cand_v[1] = ctl.upper_valid && ctl.col_end;
		cand_v[2] = ctl.last_row && !ctl.col_zero;
		cand_v[3] = ctl.last_row && ctl.col_end;
	end

	// pack the due results to the front, in order
	always_comb begin
		res_list = '0;
		res_cnt  = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				res_list[res_cnt[1:0]] = cand[i];
				res_cnt = res_cnt + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm0_old_q <= '0;
			sm0_new_q <= '0;
			df0_old_q <= '0;
			df0_new_q <= '0;
			sm1_old_q <= '0;
			sm1_new_q <= '0;
		end else if (adv) begin
			if (ctl.upper_valid) begin
				sm0_old_q <= sm0_new_q;
				sm0_new_q <= sm0;
				df0_old_q <= df0_new_q;
				df0_new_q <= df0;
			end
			if (ctl.last_row) begin
				sm1_old_q <= sm1_new_q;
				sm1_new_q <= sm1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scharr_gradient_3x3_unit.sv =====
`default_nettype none

// Streaming 3x3 Scharr gradient, single grey channel. Pixels of a frame enter
// in raster order, one beat each, and every pixel gets one result beat with its
// x and y derivative and its row and column. Borders reflect without repeating
// the edge pixel. Results of a row come out while the next row streams in, one
// column late; during the last row each pixel also releases its own last-row
// result, so those beats interleave with the row above. The input takes one
// pixel per clock while the output keeps up, and the output moves one beat per
// clock while m_axis_tready is high; that single output port sets the pace: an
// ordinary pixel yields one beat, the last pixel of a row two beats, and most
// pixels of the last row two beats (four on its final pixel). The two line
// buffers share one dual-port RAM of MAX_WIDTH words of 16 bits, read when a
// pixel is taken in and written back when the pixel moves on; a pixel following
// one of the same column (one-column images) takes the written-back word by
// forwarding. The RAM needs no clearing after reset. Writing a register
// restarts the frame at row 0, column 0; write only while idle.

module scharr_gradient_3x3_unit #(
	parameter int MAX_WIDTH = scg_pkg::MAX_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_we,
	input  wire [scg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [scg_pkg::CFG_W-1:0]     cfg_wdata,
	// pixel input
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire [7:0]                    s_axis_tdata,  // [7:0] pixel
	// gradient output
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [47:0]                  m_axis_tdata,  // [12:0] grad_x, [25:13] grad_y,
	                                                    // [37:26] out_row, [47:38] out_col
	output logic                         m_axis_tlast,  // last_of_run
	output logic                         m_axis_tuser   // frame_done
);

	import scg_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);        // column index bits
	localparam int WW  = $clog2(MAX_WIDTH + 1);    // line length bits
	localparam int EXT = (WW > IMG_W_W) ? WW : IMG_W_W;

	// registers
	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [WW-1:0]      eff_w, eff_w_m1;
	logic [IMG_H_W-1:0] eff_h, eff_h_m1;

	// raster position of the next pixel
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// stage 1: pixel waiting on its line buffer word
	logic                s1_valid_q;
	logic [PIXEL_W-1:0]  pixel_s1;
	logic [CW-1:0]       col_s1;
	ctl_t                ctl_s1;
	logic                fwd_s1;
	logic [15:0]         fwd_data_s1;

	// stage 2: results of one pixel, head first
	res_t [3:0]          q_s2;
	logic [2:0]          cnt_s2;

	logic        in_fire, s1_fire, s2_take, out_fire;
	logic [15:0] ram_rdata, line_word, wb_data;
	ctl_t        ctl_in;
	res_t [3:0]  res_list;
	logic [2:0]  res_cnt;

	// clamp the geometry to what the line store holds
	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (EXT'(width_q) > EXT'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		eff_h    = (height_q == '0) ? IMG_H_W'(1) : height_q;
		eff_w_m1 = eff_w - WW'(1);
		eff_h_m1 = eff_h - IMG_H_W'(1);
	end

	// handshakes: stage 2 frees when empty or its final beat leaves
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign s2_take       = (cnt_s2 == '0) || (out_fire && cnt_s2 == 3'd1);
	assign s1_fire       = s1_valid_q && s2_take;
	assign s_axis_tready = !s1_valid_q || s1_fire;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// position flags for the pixel being taken in
	always_comb begin
		ctl_in.upper_valid = (row_q != '0);
		ctl_in.has_above   = (row_q[ROW_W-1:1] != '0);
		ctl_in.last_row    = (row_q == eff_h_m1);
		ctl_in.height_one  = (eff_h == IMG_H_W'(1));
		ctl_in.col_zero    = (col_q == '0);
		ctl_in.col_one     = (col_q == CW'(1));
		ctl_in.col_end     = (WW'(col_q) == eff_w_m1);
		ctl_in.row         = row_q;
		ctl_in.col         = COL_W'(col_q);
	end

	// configuration writes restart the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_WIDTH_RST;
			height_q <= IMAGE_HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_wdata[IMG_W_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_wdata[IMG_H_W-1:0];
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			// advance along the raster, wrap at the end of the frame
			if (WW'(col_q) == eff_w_m1) begin
				col_q <= '0;
				row_q <= (row_q == eff_h_m1) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line buffer word: [15:8] two rows back, [7:0] one row back
	assign line_word = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign wb_data   = {line_word[7:0], pixel_s1};

	scg_line_ram #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (16)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (col_q),
		.rd_data (ram_rdata),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (wb_data)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload; forward the write-back when the same column follows
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_s1    <= s_axis_tdata[PIXEL_W-1:0];
			col_s1      <= col_q;
			ctl_s1      <= ctl_in;
			fwd_s1      <= s1_fire && (col_s1 == col_q);
			fwd_data_s1 <= wb_data;
		end
	end

	scg_grad_calc u_grad_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (s1_fire),
		.ctl      (ctl_s1),
		.pixel    (pixel_s1),
		.older    (line_word[15:8]),
		.newer    (line_word[7:0]),
		.res_list (res_list),
		.res_cnt  (res_cnt)
	);

	// stage 2: load a pixel's results, drop the head on each beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (s1_fire) begin
			cnt_s2 <= res_cnt;
		end else if (out_fire) begin
			cnt_s2 <= cnt_s2 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			q_s2 <= res_list;
		end else if (out_fire) begin
			for (int i = 0; i < 3; i++) begin
				q_s2[i] <= q_s2[i+1];
			end
			q_s2[3] <= '0;
		end
	end

	assign m_axis_tvalid = (cnt_s2 != '0);
	assign m_axis_tdata  = {q_s2[0].col, q_s2[0].row, q_s2[0].grad_y, q_s2[0].grad_x};
	assign m_axis_tlast  = (cnt_s2 == 3'd1);
	assign m_axis_tuser  = q_s2[0].done;

endmodule

`default_nettype wire
